// File: hw/rtl/sha1_pkg.sv
package sha1_pkg;

  localparam int BLOCK_BITS  = 512;
  localparam int BLOCK_BYTES = BLOCK_BITS / 8;
  localparam int FILL_W      = $clog2(BLOCK_BYTES);
  localparam int COUNT_W     = 61;
  localparam int LEN_W       = COUNT_W + 3;
  localparam int LEN_START   = BLOCK_BYTES - LEN_W / 8;
  localparam int WIN_DEPTH   = 16;
  localparam int ROUNDS      = 80;
  localparam int ROUND_W     = $clog2(ROUNDS);
  localparam int DIGEST_WORDS = 5;
  localparam int OUT_CNT_W   = $clog2(DIGEST_WORDS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } result_t;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] data;
    logic                  is_final;
  } block_t;

  typedef struct packed {
    logic   push;
    block_t blk;
  } blk_push_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

// File: hw/rtl/sha1_hash_engine_core.sv
// Channel   Handshake        Payload               Transaction
// --------  ---------------  --------------------  ---------------------------------
// item      push / full      sha1_pkg::item_t      one message byte, or an end mark
// result    pop / empty      sha1_pkg::result_t    one digest word, H0 first
//
// Flow: the front takes one byte a cycle into a 64-byte shift line, but not
// while it pads or while a block's last byte waits on a full block queue; the
// back runs one SHA-1 round a cycle, and the round loop sets the sustained rate.
// At the end of a message the front inserts padding at one byte a cycle, held
// at a block's last byte while the block queue is full, and full stays high.
// Reset: rst is synchronous; it restores the initial chaining values and empties
// both queues. Stalls: an unread digest stalls the back only at a final block.
module sha1_hash_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sha1_pkg::item_t    item,
  output logic               empty,
  input  logic               pop,
  output sha1_pkg::result_t  result
);

  sha1_pkg::blk_push_t q_wr;
  sha1_pkg::block_t    q_data;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;

  // Front: pack bytes, append padding and the bit length, hand off full blocks.
  sha1_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // Two-block queue: hold finished blocks while the rounds are busy.
  sha1_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_empty (q_empty),
    .rd_data (q_data)
  );

  // Back: compress each block, fold into the chain, shift out the digest.
  sha1_core u_core (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// File: hw/rtl/sha1_front.sv
module sha1_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sha1_pkg::item_t    item,
  input  logic               q_full,
  output sha1_pkg::blk_push_t q_wr
);

  typedef enum logic [1:0] {
    F_ACCEPT = 2'b01,
    F_PAD    = 2'b10
  } fstate_t;

  fstate_t                               state, state_next;
  logic [sha1_pkg::FILL_W-1:0]           fill;
  logic [sha1_pkg::COUNT_W-1:0]          count;
  logic [sha1_pkg::BLOCK_BITS-1:0]       blk;
  logic                                  marked;
  logic                                  len_ready;
  logic [sha1_pkg::LEN_W-1:0]            len_bits;
  logic                                  blocked;
  logic                                  accept;
  logic                                  wr_en;
  logic [7:0]                            wr_byte;
  logic                                  len_phase;
  logic                                  at_end;
  logic [sha1_pkg::BLOCK_BITS-1:0]       blk_next;

  assign at_end    = (fill == sha1_pkg::FILL_W'(sha1_pkg::BLOCK_BYTES - 1));
  assign blocked   = at_end && q_full;
  assign full      = (state != F_ACCEPT) || blocked;
  assign accept    = push && !full;
  assign len_bits  = {count, 3'b000};
  assign len_phase = marked && len_ready &&
                     (fill >= sha1_pkg::FILL_W'(sha1_pkg::LEN_START));
  assign blk_next  = {blk[sha1_pkg::BLOCK_BITS-9:0], wr_byte};

  always_comb begin
    wr_en      = 1'b0;
    wr_byte    = item.data_byte;
    state_next = state;
    unique case (state)
      F_ACCEPT: begin
        wr_en = accept && item.byte_present;
        if (accept && item.last) begin
          state_next = F_PAD;
        end
      end
      F_PAD: begin
        wr_en = !blocked;
        if (!marked) begin
          wr_byte = sha1_pkg::PAD_MARK;
        end else if (len_phase) begin
          wr_byte = len_bits[{~fill[2:0], 3'b000} +: 8];
        end else begin
          wr_byte = 8'h00;
        end
        if (wr_en && len_phase && at_end) begin
          state_next = F_ACCEPT;
        end
      end
      default: state_next = F_ACCEPT;
    endcase
  end

  always_comb begin
    q_wr.push         = wr_en && at_end;
    q_wr.blk.data     = blk_next;
    q_wr.blk.is_final = (state == F_PAD) && len_phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_ACCEPT;
      fill      <= '0;
      count     <= '0;
      marked    <= 1'b0;
      len_ready <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        fill <= fill + 1'b1;
      end
      if (state == F_ACCEPT) begin
        marked    <= 1'b0;
        len_ready <= 1'b0;
        if (wr_en) begin
          count <= count + 1'b1;
        end
      end else if (wr_en) begin
        if (len_phase && at_end) begin
          count <= '0;
        end
        if (!marked) begin
          marked    <= 1'b1;
          len_ready <= (fill < sha1_pkg::FILL_W'(sha1_pkg::LEN_START)) || at_end;
        end else if (at_end) begin
          len_ready <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk <= blk_next;
    end
  end

endmodule

// File: hw/rtl/sha1_queue.sv
module sha1_queue (
  input  logic                clk,
  input  logic                rst,
  input  sha1_pkg::blk_push_t wr,
  output logic                q_full,
  input  logic                rd,
  output logic                q_empty,
  output sha1_pkg::block_t    rd_data
);

  sha1_pkg::block_t                    entries [sha1_pkg::QUEUE_DEPTH];
  logic [sha1_pkg::QUEUE_PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [sha1_pkg::QUEUE_CNT_W-1:0]    cnt;
  logic                                do_wr, do_rd;

  assign q_full  = (cnt == sha1_pkg::QUEUE_CNT_W'(sha1_pkg::QUEUE_DEPTH));
  assign q_empty = (cnt == '0);
  assign do_wr   = wr.push && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr.blk;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr.push |-> !q_full)
    else $error("block pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !q_empty)
    else $error("block popped from an empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= sha1_pkg::QUEUE_CNT_W'(sha1_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// File: hw/rtl/sha1_core.sv
module sha1_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  sha1_pkg::block_t   q_data,
  output logic               empty,
  input  logic               pop,
  output sha1_pkg::result_t  result
);

  typedef enum logic [2:0] {
    C_IDLE   = 3'b001,
    C_ROUND  = 3'b010,
    C_FINISH = 3'b100
  } cstate_t;

  cstate_t                               state;
  logic [sha1_pkg::ROUND_W-1:0]          rnd;
  logic [31:0]                           a, b, c, d, e;
  logic [31:0]                           win [sha1_pkg::WIN_DEPTH];
  logic [31:0]                           h   [sha1_pkg::DIGEST_WORDS];
  logic [31:0]                           sum [sha1_pkg::DIGEST_WORDS];
  logic                                  is_final;
  logic [32*sha1_pkg::DIGEST_WORDS-1:0]  out_buf;
  logic [sha1_pkg::OUT_CNT_W-1:0]        out_cnt;
  logic [31:0]                           wt, f, k, t;
  logic                                  last_round;

  assign q_pop      = (state == C_IDLE) && !q_empty;
  assign last_round = (rnd == sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS - 1));

  always_comb begin
    if (rnd < sha1_pkg::ROUND_W'(sha1_pkg::WIN_DEPTH)) begin
      wt = win[0];
    end else begin
      wt = sha1_pkg::rotl(win[13] ^ win[8] ^ win[2] ^ win[0], 1);
    end
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K3;
    end
    t = sha1_pkg::rotl(a, 5) + f + e + k + wt;
  end

  always_comb begin
    sum[0] = h[0] + a;
    sum[1] = h[1] + b;
    sum[2] = h[2] + c;
    sum[3] = h[3] + d;
    sum[4] = h[4] + e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      rnd     <= '0;
      out_cnt <= '0;
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
        h[i] <= sha1_pkg::H_INIT[i];
      end
    end else begin
      if (pop && !empty) begin
        out_cnt <= out_cnt - 1'b1;
      end
      unique case (state)
        C_IDLE: begin
          if (!q_empty) begin
            rnd   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          if (last_round) begin
            rnd   <= '0;
            state <= C_FINISH;
          end else begin
            rnd <= rnd + 1'b1;
          end
        end
        C_FINISH: begin
          if (!is_final) begin
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
              h[i] <= sum[i];
            end
            state <= C_IDLE;
          end else if (empty) begin
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
              h[i] <= sha1_pkg::H_INIT[i];
            end
            out_cnt <= sha1_pkg::OUT_CNT_W'(sha1_pkg::DIGEST_WORDS);
            state   <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // datapath: window, working variables, digest shift-out
  always_ff @(posedge clk) begin
    if (state == C_IDLE && !q_empty) begin
      for (int i = 0; i < sha1_pkg::WIN_DEPTH; i++) begin
        win[i] <= q_data.data[sha1_pkg::BLOCK_BITS-1-32*i -: 32];
      end
      a        <= h[0];
      b        <= h[1];
      c        <= h[2];
      d        <= h[3];
      e        <= h[4];
      is_final <= q_data.is_final;
    end else if (state == C_ROUND) begin
      for (int i = 0; i < sha1_pkg::WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[sha1_pkg::WIN_DEPTH-1] <= wt;
      a <= t;
      b <= a;
      c <= sha1_pkg::rotl(b, 30);
      d <= c;
      e <= d;
    end
    if (state == C_FINISH && is_final && empty) begin
      out_buf <= {sum[0], sum[1], sum[2], sum[3], sum[4]};
    end else if (pop && !empty) begin
      out_buf <= {out_buf[32*(sha1_pkg::DIGEST_WORDS-1)-1:0], 32'h0};
    end
  end

  assign empty              = (out_cnt == '0);
  assign result.digest_word = out_buf[32*sha1_pkg::DIGEST_WORDS-1 -: 32];
  assign result.last_word   = (out_cnt == sha1_pkg::OUT_CNT_W'(1));

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    rnd < sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS))
    else $error("round counter out of range");

  a_round_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == C_ROUND && last_round) |=> state == C_FINISH)
    else $error("compression did not finish after the last round");

  a_out_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_cnt <= sha1_pkg::OUT_CNT_W'(sha1_pkg::DIGEST_WORDS))
    else $error("digest word count out of range");

  a_no_digest_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == C_FINISH && is_final && !empty) |=> state == C_FINISH)
    else $error("digest loaded while previous digest still pending");

endmodule
